FILE: hdl/touch_sample_average_scale_macros.svh
// Assertion macros shared by the touch sample averaging block.
`ifndef TOUCH_SAMPLE_AVERAGE_SCALE_MACROS_SVH
`define TOUCH_SAMPLE_AVERAGE_SCALE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSAS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tsas_pkg.sv
// Shared types, constants and codes for the touch sample averaging block.
package tsas_pkg;

  // Field and datapath widths
  localparam int COORD_W   = 10;
  localparam int COUNT_W   = 16;
  localparam int REG_IDX_W = 3;
  localparam int DIVD_W    = 2 * COORD_W;

  // Defaults for the top-level parameters and the ADC resolution
  localparam int SAMPLES_PER_AXIS_DEF = 5;
  localparam int ADC_BITS             = 10;
  localparam logic [COORD_W-1:0] ADC_MASK = COORD_W'((1 << ADC_BITS) - 1);

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_X_LOW  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_X_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_Y_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_Y_HIGH = 3'd5;

  // Reset values of the registers and the window
  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST   = 10'd320;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST  = 10'd240;
  localparam logic [COORD_W-1:0] DEFAULT_X_LOW_RST  = 10'd200;
  localparam logic [COORD_W-1:0] DEFAULT_X_HIGH_RST = 10'd750;
  localparam logic [COORD_W-1:0] DEFAULT_Y_LOW_RST  = 10'd120;
  localparam logic [COORD_W-1:0] DEFAULT_Y_HIGH_RST = 10'd620;

  // Input item
  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] sample;
  } item_t;

  // Result item
  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               in_range;
    logic               calibrating;
    logic [COUNT_W-1:0] touch_count;
  } result_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XAVG,
    ST_YAVG,
    ST_JUDGE,
    ST_MULX,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_MULY,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic {AXIS_X, AXIS_Y} axis_t;

  // Controller to datapath
  typedef struct packed {
    logic     accum;        // add sample, advance index
    logic     calib_begin;  // reload default window, start calibration
    logic     div_start;
    axis_t    axis;         // axis for multiply, divisor and position save
    logic     save_x_avg;
    logic     save_y_avg;
    logic     judge;        // register the window test
    logic     mult;         // product of screen size and offset
    logic     save_pos;
    logic     finish;       // load result, update count and calibration
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_x;
    logic last_y;
    logic div_busy;
    logic in_range;
    logic span_x_zero;
    logic span_y_zero;
    logic calib_active;
    logic out_blocked;
  } status_t;

endpackage

FILE: hdl/tsas_div.sv
// Restoring divider: one quotient bit per cycle, quotient known to fit COORD_W bits.
module tsas_div import tsas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [COORD_W-1:0] divisor,
  output logic              busy,
  output logic [COORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic [CNT_W-1:0]   cnt;
  logic [COORD_W-1:0] rem;
  logic [COORD_W-1:0] dq;     // remaining dividend bits, quotient shifts in
  logic [COORD_W-1:0] dsr;
  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   trial_sub;
  logic               ge;

  assign busy     = (cnt != '0);
  assign quotient = dq;

  // One restoring step
  always_comb begin
    trial     = {rem, dq[COORD_W-1]};
    trial_sub = trial - {1'b0, dsr};
    ge        = (trial >= {1'b0, dsr});
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(COORD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder and quotient shift registers; upper half starts below divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DIVD_W-1:COORD_W];
      dq  <= dividend[COORD_W-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? trial_sub[COORD_W-1:0] : trial[COORD_W-1:0];
      dq  <= {dq[COORD_W-2:0], ge};
    end
  end

endmodule

FILE: hdl/tsas_ctrl.sv
// Sequencer for averaging, window test, scaling and result hand-off.
module tsas_ctrl import tsas_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_op,
  output logic    item_stall,
  output cmd_t    cmd,
  input  status_t status
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (item_op) begin
            cmd.calib_begin = 1'b1;
          end else begin
            cmd.accum = 1'b1;
            if (status.last_x) begin
              state_next = ST_XAVG;
            end else if (status.last_y) begin
              state_next = ST_YAVG;
            end
          end
        end
      end
      ST_XAVG: begin
        cmd.save_x_avg = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_YAVG: begin
        cmd.save_y_avg = 1'b1;
        state_next     = ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = ST_MULX;
      end
      ST_MULX: begin
        if (!status.in_range) begin
          state_next = ST_FINISH;
        end else begin
          cmd.mult = 1'b1;
          cmd.axis = AXIS_X;
          // zero span leaves the cleared position
          state_next = status.span_x_zero ? ST_MULY : ST_DIVX_GO;
        end
      end
      ST_DIVX_GO: begin
        cmd.div_start = 1'b1;
        cmd.axis      = AXIS_X;
        state_next    = ST_DIVX_WAIT;
      end
      ST_DIVX_WAIT: begin
        if (!status.div_busy) begin
          cmd.save_pos = 1'b1;
          cmd.axis     = AXIS_X;
          state_next   = ST_MULY;
        end
      end
      ST_MULY: begin
        cmd.mult   = 1'b1;
        cmd.axis   = AXIS_Y;
        state_next = status.span_y_zero ? ST_FINISH : ST_DIVY_GO;
      end
      ST_DIVY_GO: begin
        cmd.div_start = 1'b1;
        cmd.axis      = AXIS_Y;
        state_next    = ST_DIVY_WAIT;
      end
      ST_DIVY_WAIT: begin
        if (!status.div_busy) begin
          cmd.save_pos = 1'b1;
          cmd.axis     = AXIS_Y;
          state_next   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait until the output register can take the result
        if (!status.out_blocked) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/tsas_dp.sv
// Datapath: registers, accumulator, window, multiplier, divider and output register.
module tsas_dp import tsas_pkg::*; #(
  parameter int SAMPLES_PER_AXIS = SAMPLES_PER_AXIS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  item_t                item,
  input  logic                 cfg_wen,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 result_stall,
  output logic                 result_valid,
  output result_t              result
);

  localparam int IDX_W = $clog2(2 * SAMPLES_PER_AXIS);
  localparam int SUM_W = COORD_W + $clog2(SAMPLES_PER_AXIS);
  localparam logic [IDX_W:0] LAST_X = (IDX_W + 1)'(SAMPLES_PER_AXIS);
  localparam logic [IDX_W:0] LAST_Y = (IDX_W + 1)'(2 * SAMPLES_PER_AXIS);

  // Reciprocal of the sample count, exact for every sum below 2**SUM_W
  localparam int RECIP_S = SUM_W + $clog2(SAMPLES_PER_AXIS);
  localparam int RECIP_W = RECIP_S + 1;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((1 << RECIP_S) + SAMPLES_PER_AXIS - 1) / SAMPLES_PER_AXIS);

  // Configuration registers
  logic [COORD_W-1:0] screen_w, screen_h;
  logic [COORD_W-1:0] dflt_xl, dflt_xh, dflt_yl, dflt_yh;

  // Window and calibration state
  logic [COORD_W-1:0] win_xl, win_xh, win_yl, win_yh;
  logic               calib, first_taken;
  logic [COORD_W-1:0] first_x, first_y;

  // Touch accumulation
  logic [IDX_W-1:0]         idx;
  logic [IDX_W:0]           idx_inc;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W+RECIP_W-1:0] avg_prod;
  logic [COORD_W-1:0]       avg_quot;
  logic [COORD_W-1:0]       x_avg, y_avg;

  // Scaling
  logic               in_range;
  logic [COORD_W-1:0] m_size, m_off;
  logic [DIVD_W-1:0]  prod;
  logic [COORD_W-1:0] pos_x_s, pos_y_s;
  logic [COORD_W-1:0] span_x, span_y;
  logic [COORD_W-1:0] div_divisor;
  logic               div_busy;
  logic [COORD_W-1:0] quotient;
  logic [COUNT_W-1:0] touches;
  logic [COUNT_W-1:0] touches_inc;
  logic               window_ok;

  tsas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Combinational helpers
  always_comb begin
    idx_inc     = {1'b0, idx} + 1'b1;
    span_x      = win_xh - win_xl;
    span_y      = win_yh - win_yl;
    touches_inc = touches + 1'b1;
    window_ok   = !calib && (x_avg >= win_xl) && (x_avg <= win_xh) &&
                  (y_avg >= win_yl) && (y_avg <= win_yh);
    m_size      = (cmd.axis == AXIS_X) ? screen_w : screen_h;
    m_off       = (cmd.axis == AXIS_X) ? (x_avg - win_xl) : (y_avg - win_yl);
    div_divisor = (cmd.axis == AXIS_X) ? span_x : span_y;
    // axis average: sum over the sample count by reciprocal multiply
    avg_prod    = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP_M};
    avg_quot    = avg_prod[RECIP_S +: COORD_W];
  end

  // Status to the controller
  always_comb begin
    status.last_x       = (idx_inc == LAST_X);
    status.last_y       = (idx_inc == LAST_Y);
    status.div_busy     = div_busy;
    status.in_range     = in_range;
    status.span_x_zero  = (win_xh == win_xl);
    status.span_y_zero  = (win_yh == win_yl);
    status.calib_active = calib;
    status.out_blocked  = result_valid && result_stall;
  end

  // Configuration write port; unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= SCREEN_WIDTH_RST;
      screen_h <= SCREEN_HEIGHT_RST;
      dflt_xl  <= DEFAULT_X_LOW_RST;
      dflt_xh  <= DEFAULT_X_HIGH_RST;
      dflt_yl  <= DEFAULT_Y_LOW_RST;
      dflt_yh  <= DEFAULT_Y_HIGH_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:   screen_w <= cfg_data;
        REG_SCREEN_HEIGHT:  screen_h <= cfg_data;
        REG_DEFAULT_X_LOW:  dflt_xl  <= cfg_data;
        REG_DEFAULT_X_HIGH: dflt_xh  <= cfg_data;
        REG_DEFAULT_Y_LOW:  dflt_yl  <= cfg_data;
        REG_DEFAULT_Y_HIGH: dflt_yh  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample index and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      sum <= '0;
    end else if (cmd.accum) begin
      idx <= idx_inc[IDX_W-1:0];
      sum <= sum + SUM_W'(item.sample & ADC_MASK);
    end else if (cmd.save_x_avg) begin
      sum <= '0;
    end else if (cmd.save_y_avg) begin
      sum <= '0;
      idx <= '0;
    end
  end

  // Axis averages and scaled positions
  always_ff @(posedge clk) begin
    if (cmd.save_x_avg) begin
      x_avg <= avg_quot;
    end
    if (cmd.save_y_avg) begin
      y_avg <= avg_quot;
    end
    if (cmd.judge) begin
      in_range <= window_ok;
    end
    if (cmd.mult) begin
      prod <= {{COORD_W{1'b0}}, m_size} * {{COORD_W{1'b0}}, m_off};
      if (cmd.axis == AXIS_X) begin
        pos_x_s <= '0;
      end else begin
        pos_y_s <= '0;
      end
    end
    if (cmd.save_pos) begin
      if (cmd.axis == AXIS_X) begin
        pos_x_s <= quotient;
      end else begin
        pos_y_s <= quotient;
      end
    end
  end

  // Window, calibration flags and touch count
  always_ff @(posedge clk) begin
    if (rst) begin
      win_xl      <= DEFAULT_X_LOW_RST;
      win_xh      <= DEFAULT_X_HIGH_RST;
      win_yl      <= DEFAULT_Y_LOW_RST;
      win_yh      <= DEFAULT_Y_HIGH_RST;
      calib       <= 1'b0;
      first_taken <= 1'b0;
      touches     <= '0;
    end else if (cmd.calib_begin) begin
      win_xl      <= dflt_xl;
      win_xh      <= dflt_xh;
      win_yl      <= dflt_yl;
      win_yh      <= dflt_yh;
      calib       <= 1'b1;
      first_taken <= 1'b0;
    end else if (cmd.finish) begin
      touches <= touches_inc;
      if (calib) begin
        if (!first_taken) begin
          first_taken <= 1'b1;
        end else begin
          // second calibration touch sets the window from both points
          win_xl      <= (x_avg < first_x) ? x_avg : first_x;
          win_xh      <= (x_avg < first_x) ? first_x : x_avg;
          win_yl      <= (y_avg < first_y) ? y_avg : first_y;
          win_yh      <= (y_avg < first_y) ? first_y : y_avg;
          first_taken <= 1'b0;
          calib       <= 1'b0;
        end
      end
    end
  end

  // First calibration point
  always_ff @(posedge clk) begin
    if (cmd.finish && calib && !first_taken) begin
      first_x <= x_avg;
      first_y <= y_avg;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.pos_x       <= in_range ? pos_x_s : x_avg;
      result.pos_y       <= in_range ? pos_y_s : y_avg;
      result.in_range    <= in_range;
      result.calibrating <= calib && !first_taken;
      result.touch_count <= touches_inc;
    end
  end

endmodule

FILE: hdl/touch_sample_average_scale.sv
// Top level: touch ADC averaging with window test, scaling and two-point calibration.
//
//   channel  | dir | handshake                  | payload
//   ---------+-----+----------------------------+-------------------------------
//   item     | in  | item_valid / item_stall    | item_t   (operation, sample)
//   result   | out | result_valid / result_stall| result_t (pos, flags, count)
//   cfg      | in  | cfg_wen                    | cfg_index, cfg_data
//
// Ordinary samples and begin-calibration items are taken while idle; after the last X sample
// the X average is latched from a reciprocal multiply of the sum before the next item is taken.
// After the last Y sample come the Y average and the window test, then in range per axis a
// registered multiply and a restoring division, plus any output stall, before the next item.
// Reset is synchronous; control, configuration, window, flags and count return to defaults, data registers do not.
// A stalled result is held; samples are still taken until the next result is due.
`include "touch_sample_average_scale_macros.svh"

module touch_sample_average_scale import tsas_pkg::*; #(
  parameter int SAMPLES_PER_AXIS = SAMPLES_PER_AXIS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_wen,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  cmd_t    cmd;
  status_t status;

  tsas_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_op    (item.operation),
    .item_stall (item_stall),
    .cmd        (cmd),
    .status     (status)
  );

  tsas_dp #(
    .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  // Checks
  `TSAS_ASSERT_IMPLY(a_accept_div_idle, item_valid && !item_stall, !status.div_busy, "item taken while divider busy")
  `TSAS_ASSERT_IMPLY(a_start_div_idle, cmd.div_start, !status.div_busy, "divider restarted while busy")
  `TSAS_ASSERT_IMPLY(a_finish_no_overwrite, cmd.finish, !(result_valid && result_stall), "result overwritten")
  `TSAS_ASSERT_NEXT(a_calib_begin, item_valid && !item_stall && item.operation, status.calib_active, "calibration not started")

endmodule

FILE: tb/sv/tb_touch_sample_average_scale.sv
// Self-checking testbench for the touch sample averaging and scaling block.
`timescale 1ns / 100ps

module tb_touch_sample_average_scale;
  import tsas_pkg::*;

  localparam int AXIS_SAMPLES  = SAMPLES_PER_AXIS_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int PHASE_ITEMS   = 375;

  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

  // Indexes past the last register; writes there must be ignored
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_wen      = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index    = '0;
  logic [COORD_W-1:0]   cfg_data     = '0;

  // Predictor registers
  logic [COORD_W-1:0] scr_w   = SCREEN_WIDTH_RST;
  logic [COORD_W-1:0] scr_h   = SCREEN_HEIGHT_RST;
  logic [COORD_W-1:0] def_xlo = DEFAULT_X_LOW_RST;
  logic [COORD_W-1:0] def_xhi = DEFAULT_X_HIGH_RST;
  logic [COORD_W-1:0] def_ylo = DEFAULT_Y_LOW_RST;
  logic [COORD_W-1:0] def_yhi = DEFAULT_Y_HIGH_RST;

  // Predictor state
  logic [3:0]         sample_cnt  = '0;
  logic [12:0]        axis_sum    = '0;
  logic [COORD_W-1:0] x_avg       = '0;
  logic [COORD_W-1:0] win_xlo     = DEFAULT_X_LOW_RST;
  logic [COORD_W-1:0] win_xhi     = DEFAULT_X_HIGH_RST;
  logic [COORD_W-1:0] win_ylo     = DEFAULT_Y_LOW_RST;
  logic [COORD_W-1:0] win_yhi     = DEFAULT_Y_HIGH_RST;
  logic               calib_on    = 1'b0;
  logic               first_taken = 1'b0;
  logic [COORD_W-1:0] first_x     = '0;
  logic [COORD_W-1:0] first_y     = '0;
  logic [COUNT_W-1:0] touch_total = '0;

  result_t expected_reports[$];
  int      error_count    = 0;
  int      cycle_count    = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  touch_sample_average_scale dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    result_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic item_t make_item(input logic op, input logic [COORD_W-1:0] v);
    item_t it;
    it.operation = op;
    it.sample    = v;
    return it;
  endfunction

  // Window scaling; a zero or inverted span gives 0
  function automatic logic [COORD_W-1:0] scale_pos(input logic [COORD_W-1:0] v,
                                                    input logic [COORD_W-1:0] lo,
                                                    input logic [COORD_W-1:0] hi,
                                                    input logic [COORD_W-1:0] size);
    int unsigned prod;
    if (hi <= lo) return '0;
    prod = 32'(size) * 32'(v - lo);
    return COORD_W'(prod / 32'(hi - lo));
  endfunction

  // Advance the touch predictor by one transfer; returns 1 when a result is due
  function automatic bit predict_touch(input item_t it, output result_t res);
    logic [COORD_W-1:0] x, y, px, py;
    logic               hit;
    res = '0;
    if (it.operation == OP_CALIBRATE) begin
      win_xlo     = def_xlo;
      win_xhi     = def_xhi;
      win_ylo     = def_ylo;
      win_yhi     = def_yhi;
      first_taken = 1'b0;
      calib_on    = 1'b1;
      return 1'b0;
    end
    axis_sum   = axis_sum + 13'(it.sample & ADC_MASK);
    sample_cnt = sample_cnt + 4'd1;
    if (sample_cnt == AXIS_SAMPLES) begin
      x_avg    = COORD_W'(axis_sum / AXIS_SAMPLES);
      axis_sum = '0;
      return 1'b0;
    end
    if (sample_cnt < 2 * AXIS_SAMPLES) return 1'b0;

    x          = x_avg;
    y          = COORD_W'(axis_sum / AXIS_SAMPLES);
    axis_sum   = '0;
    sample_cnt = '0;
    hit = !calib_on && x >= win_xlo && x <= win_xhi && y >= win_ylo && y <= win_yhi;
    if (hit) begin
      px = scale_pos(x, win_xlo, win_xhi, scr_w);
      py = scale_pos(y, win_ylo, win_yhi, scr_h);
    end else begin
      px = x;
      py = y;
    end
    touch_total = touch_total + 1'b1;

    // Two calibration points set the window
    if (calib_on) begin
      if (!first_taken) begin
        first_x     = x;
        first_y     = y;
        first_taken = 1'b1;
      end else begin
        win_xlo     = (x < first_x) ? x : first_x;
        win_xhi     = (x < first_x) ? first_x : x;
        win_ylo     = (y < first_y) ? y : first_y;
        win_yhi     = (y < first_y) ? first_y : y;
        first_taken = 1'b0;
        calib_on    = 1'b0;
      end
    end

    res.pos_x       = px & ADC_MASK;
    res.pos_y       = py & ADC_MASK;
    res.in_range    = hit;
    res.calibrating = calib_on;
    res.touch_count = touch_total;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    result_t want;
    string   diffs;
    if (!rst && result_valid && !result_stall) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result with none expected: x=%0d y=%0d count=%0d",
                                  result.pos_x, result.pos_y, result.touch_count));
      end else begin
        want  = expected_reports.pop_front();
        diffs = "";
        if (result.pos_x !== want.pos_x)
          diffs = {diffs, $sformatf(" pos_x %0d/%0d", result.pos_x, want.pos_x)};
        if (result.pos_y !== want.pos_y)
          diffs = {diffs, $sformatf(" pos_y %0d/%0d", result.pos_y, want.pos_y)};
        if (result.in_range !== want.in_range)
          diffs = {diffs, $sformatf(" in_range %0b/%0b", result.in_range, want.in_range)};
        if (result.calibrating !== want.calibrating)
          diffs = {diffs, $sformatf(" calibrating %0b/%0b",
                                    result.calibrating, want.calibrating)};
        if (result.touch_count !== want.touch_count)
          diffs = {diffs, $sformatf(" touch_count %0d/%0d",
                                    result.touch_count, want.touch_count)};
        if (diffs != "")
          report_mismatch({"touch result (got/exp):", diffs});
      end
    end
  end

  // One input transfer, with random sender gaps ahead of it
  task automatic send_item(input item_t it);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    if (predict_touch(it, res)) expected_reports.push_back(res);
  endtask

  // Constant X and Y readings over a whole touch
  task automatic send_touch(input logic [COORD_W-1:0] xv, input logic [COORD_W-1:0] yv);
    repeat (AXIS_SAMPLES) send_item(make_item(OP_SAMPLE, xv));
    repeat (AXIS_SAMPLES) send_item(make_item(OP_SAMPLE, yv));
  endtask

  // Hold off until every result is in and the block has gone quiet
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH:   scr_w   = data;
      REG_SCREEN_HEIGHT:  scr_h   = data;
      REG_DEFAULT_X_LOW:  def_xlo = data;
      REG_DEFAULT_X_HIGH: def_xhi = data;
      REG_DEFAULT_Y_LOW:  def_ylo = data;
      REG_DEFAULT_Y_HIGH: def_yhi = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                              input logic [COORD_W-1:0] xlo, input logic [COORD_W-1:0] xhi,
                              input logic [COORD_W-1:0] ylo, input logic [COORD_W-1:0] yhi,
                              input bit with_unused);
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_DEFAULT_X_LOW, xlo);
    write_reg(REG_DEFAULT_X_HIGH, xhi);
    write_reg(REG_DEFAULT_Y_LOW, ylo);
    write_reg(REG_DEFAULT_Y_HIGH, yhi);
    if (with_unused) begin
      write_reg(REG_UNUSED_6, 10'h3ff);
      write_reg(REG_UNUSED_7, 10'h155);
    end
    cfg_wen <= 1'b0;
  endtask

  // Mostly well-formed touches biased into the window, with calibration
  // starts and drain pauses mixed in
  task automatic run_random(input int n, input int send_pct, input int stall_pct);
    int unsigned        pick;
    logic [COORD_W-1:0] lo, hi, v;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick == 0) wait_idle();
      if (pick < 3) begin
        send_item(make_item(OP_CALIBRATE, COORD_W'($urandom)));
      end else begin
        lo = (sample_cnt < AXIS_SAMPLES) ? win_xlo : win_ylo;
        hi = (sample_cnt < AXIS_SAMPLES) ? win_xhi : win_yhi;
        if ($urandom_range(99) < 65 && lo <= hi) v = COORD_W'($urandom_range(hi, lo));
        else v = COORD_W'($urandom_range(1023, 0));
        send_item(make_item(OP_SAMPLE, v));
      end
    end
  endtask

  // Field extremes outside the window, then the low-X, high-Y window corner
  task automatic test_window_edges();
    send_touch(10'd0, 10'd1023);
    send_touch(DEFAULT_X_LOW_RST, DEFAULT_Y_HIGH_RST);
    wait_idle();
  endtask

  // Calibration restarted mid-touch, equal points give a zero-span window
  task automatic test_calibration();
    send_item(make_item(OP_CALIBRATE, 10'h3ff));
    repeat (3) send_item(make_item(OP_SAMPLE, 10'd0));
    send_item(make_item(OP_CALIBRATE, 10'h000));
    repeat (2) send_item(make_item(OP_SAMPLE, 10'd0));
    repeat (AXIS_SAMPLES) send_item(make_item(OP_SAMPLE, 10'd1023));
    send_touch(10'd0, 10'd1023);
    send_touch(10'd0, 10'd1023);
    wait_idle();
  endtask

  task automatic test_random_no_idle();
    program_regs(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, DEFAULT_X_LOW_RST,
                 DEFAULT_X_HIGH_RST, DEFAULT_Y_LOW_RST, DEFAULT_Y_HIGH_RST, 1'b0);
    send_item(make_item(OP_CALIBRATE, 10'd0));
    run_random(PHASE_ITEMS, 0, 0);
  endtask

  task automatic test_random_sender_gaps();
    program_regs(10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 1'b0);
    send_item(make_item(OP_CALIBRATE, 10'd0));
    run_random(PHASE_ITEMS, 73, 0);
  endtask

  // Zero screen width, inverted default window, writes past the last register
  task automatic test_random_result_stall();
    program_regs(10'd0, 10'd1, 10'd1023, 10'd0, 10'd1023, 10'd0, 1'b1);
    send_item(make_item(OP_CALIBRATE, 10'd0));
    run_random(PHASE_ITEMS, 0, 73);
  endtask

  task automatic test_random_both_idle();
    program_regs(COORD_W'($urandom_range(1023, 1)), COORD_W'($urandom_range(1023, 1)),
                 COORD_W'($urandom_range(400, 0)), COORD_W'($urandom_range(1023, 600)),
                 COORD_W'($urandom_range(400, 0)), COORD_W'($urandom_range(1023, 600)), 1'b0);
    send_item(make_item(OP_CALIBRATE, 10'd0));
    run_random(PHASE_ITEMS, 31, 31);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_window_edges();
    test_calibration();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_result_stall();
    test_random_both_idle();
    wait_idle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: touch_sample_average_scale.f
+incdir+hdl
hdl/tsas_pkg.sv
hdl/tsas_div.sv
hdl/tsas_ctrl.sv
hdl/tsas_dp.sv
hdl/touch_sample_average_scale.sv
tb/sv/tb_touch_sample_average_scale.sv
